FILE: sv/ssi_pkg.sv
// Package for the sorted set block: command and status codes, default sizes,
// and the request and response transfer structs.
// No dependencies; imported by ssi_ram users and the top level.
package ssi_pkg;

	// Default sizes
	localparam int CAPACITY_DEF    = 256;
	localparam int VALUE_WIDTH_DEF = 32;

	// Command codes
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_GET    = 2'd2;
	localparam logic [1:0] CMD_CLEAR  = 2'd3;

	// Status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_DUP   = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [31:0] value;
		logic [7:0]         index;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] data;
		logic [8:0]         count;
		logic               removed;
	} rsp_t;

endpackage

FILE: sv/ssi_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependencies.
module ssi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port, then registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/sorted_set_insert_remove.sv
// Sorted set of distinct signed values held in one RAM, ascending, plus a count.
// Insert and remove stream one RAM read per held entry and shift in the same pass;
// insert stops early at a duplicate or a full refusal. Get reads one entry, an
// out-of-range get and clear read none; one command at a time, the next transfer is
// taken while the previous result still waits at the output register.
// Reset (arst_n low) empties the set at once; RAM contents stay unread until written.
module sorted_set_insert_remove import ssi_pkg::*; #(
	parameter int CAPACITY    = CAPACITY_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int AW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int EW   = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
	localparam int CMPW = (CW > 8) ? CW : 8;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_GETRD = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0]                   state_q;
	logic [CW-1:0]                cnt_q;
	logic [CW-1:0]                ptr_q;
	logic [CW-1:0]                pos_s1;
	logic                         rv_s1;
	logic                         pivot_q;
	logic [1:0]                   cmd_q;
	logic signed [VALUE_WIDTH-1:0] v_q;
	logic signed [VALUE_WIDTH-1:0] carry_q;
	logic [1:0]                   status_q;
	logic signed [31:0]           data_q;
	logic                         removed_q;
	logic                         rsp_valid_q;
	rsp_t                         rsp_q;

	logic                         mem_we;
	logic [AW-1:0]                mem_waddr;
	logic [VALUE_WIDTH-1:0]       mem_wdata;
	logic [AW-1:0]                mem_raddr;
	logic [VALUE_WIDTH-1:0]       mem_rdata;

	logic signed [VALUE_WIDTH-1:0] entry;
	logic signed [EW-1:0]          entry_ext;
	logic signed [EW-1:0]          value_ext;
	logic                          hit;
	logic                          above;
	logic                          full;
	logic                          scan_end;
	logic                          in_range;
	logic                          accept;
	logic                          rsp_free;

	ssi_ram #(
		.WIDTH(VALUE_WIDTH),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Compare and range helpers
	assign entry     = signed'(mem_rdata);
	assign entry_ext = EW'(entry);
	assign value_ext = EW'(req.value);
	assign hit       = rv_s1 && (entry == v_q);
	assign above     = entry > v_q;
	assign full      = cnt_q == CW'(CAPACITY);
	assign scan_end  = (ptr_q == cnt_q) && !rv_s1;
	assign in_range  = CMPW'(req.index) < CMPW'(cnt_q);
	assign accept    = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	assign req_stall = state_q != S_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Read address: get index on transfer, else the scan pointer
	assign mem_raddr = (state_q == S_IDLE) ? AW'(req.index) : AW'(ptr_q);

	// Write back: place the new value, ripple the carry up, or pull entries down
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = AW'(pos_s1);
		mem_wdata = carry_q;
		if (state_q == S_SCAN) begin
			if (cmd_q == CMD_INSERT) begin
				if (rv_s1) begin
					if (pivot_q) begin
						mem_we = 1'b1;
					end else if (!hit && above && !full) begin
						mem_we    = 1'b1;
						mem_wdata = v_q;
					end
				end else if (scan_end && (pivot_q || !full)) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(cnt_q);
					mem_wdata = pivot_q ? carry_q : v_q;
				end
			end else if (rv_s1 && pivot_q) begin
				mem_we    = 1'b1;
				mem_waddr = AW'(pos_s1 - 1'b1);
				mem_wdata = mem_rdata;
			end
		end
	end

	// Control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			ptr_q       <= '0;
			rv_s1       <= 1'b0;
			pivot_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			// Raise the result on leaving done, drop it once transferred
			if (state_q == S_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					ptr_q   <= '0;
					rv_s1   <= 1'b0;
					pivot_q <= 1'b0;
					if (accept) begin
						case (req.command)
							CMD_INSERT, CMD_REMOVE: state_q <= S_SCAN;
							CMD_GET:                state_q <= in_range ? S_GETRD : S_DONE;
							default: begin
								cnt_q   <= '0;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_SCAN: begin
					// Stream reads ahead of the compare stage
					rv_s1 <= ptr_q != cnt_q;
					if (ptr_q != cnt_q) begin
						ptr_q <= CW'(ptr_q + 1'b1);
					end
					if (cmd_q == CMD_INSERT) begin
						if (rv_s1 && !pivot_q) begin
							if (hit || (above && full)) begin
								state_q <= S_DONE;
							end else if (above) begin
								pivot_q <= 1'b1;
							end
						end
						if (scan_end) begin
							if (pivot_q || !full) begin
								cnt_q <= CW'(cnt_q + 1'b1);
							end
							state_q <= S_DONE;
						end
					end else begin
						if (hit && !pivot_q) begin
							pivot_q <= 1'b1;
						end
						if (scan_end) begin
							if (pivot_q) begin
								cnt_q <= CW'(cnt_q - 1'b1);
							end
							state_q <= S_DONE;
						end
					end
				end
				S_GETRD: state_q <= S_DONE;
				default: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	// Payload: command latch, carry, result fields and output register
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q     <= req.command;
					v_q       <= value_ext[VALUE_WIDTH-1:0];
					data_q    <= '0;
					removed_q <= 1'b0;
					status_q  <= (req.command == CMD_GET && !in_range) ? ST_RANGE : ST_OK;
				end
			end
			S_SCAN: begin
				pos_s1 <= ptr_q;
				if (rv_s1) begin
					carry_q <= entry;
				end
				if (cmd_q == CMD_INSERT) begin
					if (rv_s1 && !pivot_q) begin
						if (hit) begin
							status_q <= ST_DUP;
						end else if (above && full) begin
							status_q <= ST_FULL;
						end
					end
					if (scan_end && !pivot_q && full) begin
						status_q <= ST_FULL;
					end
				end else if (scan_end && pivot_q) begin
					removed_q <= 1'b1;
				end
			end
			S_GETRD: data_q <= entry_ext[31:0];
			default: begin
				if (rsp_free) begin
					rsp_q.status  <= status_q;
					rsp_q.data    <= data_q;
					rsp_q.count   <= 9'(cnt_q);
					rsp_q.removed <= removed_q;
				end
			end
		endcase
	end

	// Checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_we_scan: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> state_q == S_SCAN)
		else $error("RAM write outside scan");

	a_no_full_write: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && cmd_q == CMD_INSERT) |-> (pivot_q || !full))
		else $error("insert wrote into a full table");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == S_DONE)
		else $error("response raised outside done state");

endmodule

FILE: dv/tb.sv
// Self-checking testbench for sorted_set_insert_remove: directed and random command streams
// checked against an ordered-set mirror. Depends on ssi_pkg (codes, req_t, rsp_t) and the
// sorted_set_insert_remove RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ssi_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;

	// Mirror of the held set: predicts one response per request transfer, checks in order.
	class sorted_set_mirror;
		logic signed [31:0] held[$];
		rsp_t               expected[$];
		int                 mismatches;
		int                 checked;
		int                 peak;
		int                 removals;
		int                 cmd_seen[4];
		int                 status_seen[4];

		// first position whose entry is not below v
		function int lower_bound(logic signed [31:0] v);
			int pos;
			pos = 0;
			while (pos < held.size() && held[pos] < v) pos++;
			return pos;
		endfunction

		function int pending();
			return expected.size();
		endfunction

		function void note_request(req_t r);
			rsp_t e;
			int   pos;
			e = '0;
			pos = lower_bound(r.value);
			case (r.command)
				CMD_INSERT: begin
					// duplicate wins over a full table
					if (pos < held.size() && held[pos] == r.value) e.status = ST_DUP;
					else if (held.size() >= CAPACITY_DEF) e.status = ST_FULL;
					else held.insert(pos, r.value);
				end
				CMD_REMOVE: begin
					if (pos < held.size() && held[pos] == r.value) begin
						held.delete(pos);
						e.removed = 1'b1;
					end
				end
				CMD_GET: begin
					if (r.index < held.size()) e.data = held[r.index];
					else e.status = ST_RANGE;
				end
				default: held.delete();
			endcase
			e.count = 9'(held.size());
			cmd_seen[r.command]++;
			status_seen[e.status]++;
			removals += e.removed;
			if (held.size() > peak) peak = held.size();
			expected.push_back(e);
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, msg);
		endtask

		task check_response(rsp_t got);
			rsp_t e;
			if (expected.size() == 0) begin
				report($sformatf("response with nothing outstanding (status %0d count %0d)",
					got.status, got.count));
				return;
			end
			e = expected.pop_front();
			checked++;
			if (got.status !== e.status)
				report($sformatf("response %0d status %0d, want %0d", checked, got.status, e.status));
			if (got.data !== e.data)
				report($sformatf("response %0d data %0d, want %0d", checked, got.data, e.data));
			if (got.count !== e.count)
				report($sformatf("response %0d count %0d, want %0d", checked, got.count, e.count));
			if (got.removed !== e.removed)
				report($sformatf("response %0d removed %0b, want %0b", checked, got.removed,
					e.removed));
		endtask
	endclass

	logic             clk;
	logic             arst_n;
	logic             req_valid = 1'b0;
	logic             req_stall;
	req_t             req       = '0;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	rsp_t             rsp;
	bit               idle_on   = 1'b1;
	int               quiet;
	sorted_set_mirror mirror;

	sorted_set_insert_remove uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Stall the response side at random while idling is enabled
	always @(negedge clk) begin
		rsp_stall <= idle_on && ($urandom_range(0, 99) < 19);
	end

	// Check every response transfer
	always @(posedge clk) begin
		if (rsp_valid === 1'b1 && !rsp_stall) mirror.check_response(rsp);
	end

	// End the run when nothing transfers for too long
	initial begin
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)) quiet = 0;
			else quiet++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// Drive one request; return at the falling edge after its transfer
	task automatic send(logic [1:0] cmd, logic signed [31:0] v, logic [7:0] idx);
		req_t r;
		r.command = cmd;
		r.value   = v;
		r.index   = idx;
		if (idle_on && $urandom_range(0, 99) < 19) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (req_stall);
		mirror.note_request(r);
		@(negedge clk);
	endtask

	// Hold off requests until every outstanding response is back
	task automatic drain();
		req_valid <= 1'b0;
		while (mirror.pending() != 0) @(negedge clk);
	endtask

	function automatic logic signed [31:0] any_value();
		case ($urandom_range(0, 4))
			0, 1: return $urandom;
			2: return int'($urandom_range(0, 31)) - 16;
			default: begin
				case ($urandom_range(0, 5))
					0: return 32'h8000_0000;
					1: return 32'h8000_0001;
					2: return 32'h7FFF_FFFF;
					3: return 32'h7FFF_FFFE;
					4: return 32'hFFFF_FFFF;
					default: return 32'h0;
				endcase
			end
		endcase
	endfunction

	// One random command; remove and insert often hit held values
	task automatic send_random(bit allow_clear);
		int                 roll;
		int                 top;
		logic [1:0]         cmd;
		logic signed [31:0] v;
		logic [7:0]         idx;
		roll = $urandom_range(0, 99);
		v    = any_value();
		idx  = 8'($urandom);
		if (roll < 40) begin
			cmd = CMD_INSERT;
			if (mirror.held.size() != 0 && $urandom_range(0, 99) < 20)
				v = mirror.held[$urandom_range(0, mirror.held.size() - 1)];
		end else if (roll < 65) begin
			cmd = CMD_REMOVE;
			if (mirror.held.size() != 0 && $urandom_range(0, 99) < 60)
				v = mirror.held[$urandom_range(0, mirror.held.size() - 1)];
		end else if (roll < 95 || !allow_clear) begin
			cmd = CMD_GET;
			top = (mirror.held.size() > 255) ? 255 : mirror.held.size();
			if ($urandom_range(0, 99) < 70) idx = 8'($urandom_range(0, top));
		end else begin
			cmd = CMD_CLEAR;
		end
		send(cmd, v, idx);
	endtask

	initial begin
		mirror = new();
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty table, extremes, duplicate, absent remove, out-of-range get, clear
		send(CMD_GET, 0, 8'd0);
		send(CMD_REMOVE, 5, 8'd0);
		send(CMD_INSERT, 0, 8'd0);
		send(CMD_INSERT, 32'h8000_0000, 8'd0);
		send(CMD_INSERT, 32'h7FFF_FFFF, 8'd0);
		send(CMD_INSERT, -1, 8'd0);
		send(CMD_INSERT, 1, 8'd0);
		send(CMD_INSERT, 0, 8'd0);
		send(CMD_GET, 0, 8'd0);
		send(CMD_GET, 0, 8'd4);
		send(CMD_GET, 0, 8'd5);
		send(CMD_GET, 32'hFFFF_FFFF, 8'd255);
		send(CMD_REMOVE, 32'h7FFF_FFFF, 8'd0);
		send(CMD_REMOVE, 12345, 8'd0);
		send(CMD_REMOVE, 32'h8000_0000, 8'd0);
		send(CMD_GET, 0, 8'd0);
		send(CMD_CLEAR, 0, 8'd0);
		send(CMD_GET, 0, 8'd0);
		send(CMD_INSERT, 32'h5555_5555, 8'd0);
		send(CMD_INSERT, 32'hAAAA_AAAA, 8'd0);
		send(CMD_GET, 0, 8'd0);
		send(CMD_GET, 0, 8'd1);
		send(CMD_GET, 0, 8'hAA);
		send(CMD_GET, 0, 8'h55);
		drain();

		// Mixed random traffic
		repeat (40) send_random(1'b1);

		// Fill to capacity with no idling on either side
		idle_on = 1'b0;
		while (mirror.held.size() < CAPACITY_DEF) begin
			if ($urandom_range(0, 7) == 0)
				send(CMD_GET, 0, 8'($urandom_range(0, mirror.held.size())));
			else send(CMD_INSERT, $urandom, 8'($urandom));
		end
		idle_on = 1'b1;

		// Full table: duplicate, full refusal, edge reads, then churn
		send(CMD_INSERT, mirror.held[$urandom_range(0, CAPACITY_DEF - 1)], 8'd0);
		send(CMD_INSERT, $urandom, 8'd0);
		send(CMD_GET, 0, 8'd255);
		send(CMD_GET, 0, 8'd0);
		repeat (40) send_random(1'b0);
		drain();

		// Start over from an empty table
		send(CMD_CLEAR, 0, 8'd0);
		repeat (40) send_random(1'b1);

		req_valid <= 1'b0;
		while (mirror.pending() != 0) @(posedge clk);
		repeat (CAPACITY_DEF + 8) @(posedge clk);

		$display("Commands: %0d insert, %0d remove, %0d get, %0d clear; %0d responses checked",
			mirror.cmd_seen[CMD_INSERT], mirror.cmd_seen[CMD_REMOVE], mirror.cmd_seen[CMD_GET],
			mirror.cmd_seen[CMD_CLEAR], mirror.checked);
		$display("Outcomes: %0d duplicate, %0d full, %0d out of range, %0d removed, peak %0d held",
			mirror.status_seen[ST_DUP], mirror.status_seen[ST_FULL],
			mirror.status_seen[ST_RANGE], mirror.removals, mirror.peak);
		if (mirror.mismatches == 0 && mirror.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

FILE: sorted_set_insert_remove.f
sv/ssi_pkg.sv
sv/ssi_ram.sv
sv/sorted_set_insert_remove.sv
dv/tb.sv
